// ===== hw/rtl/rmwm_pkg.sv =====
// shared types, codes and constants for the row median block
`timescale 1ns / 1ps

package rmwm_pkg;

  localparam int unsigned RMWM_MAX_ROW_LENGTH = 256;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned TWICE_W    = 33;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned ROW_LEN_W  = 9;
  localparam int unsigned MODE_W     = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSING_MODE = 2'd1;

  // missing handling modes; any other code drops missing elements
  localparam logic [MODE_W-1:0] MODE_NONE      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROPAGATE = 2'd1;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_MISSING = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;
  localparam logic [1:0] STATUS_BAD     = 2'd3;

  typedef struct packed {
    logic signed [VAL_W-1:0] element_value;
    logic                    element_missing;
  } in_beat_t;

  typedef struct packed {
    logic signed [TWICE_W-1:0] twice_median;
    logic [1:0]                median_status;
  } out_beat_t;

  // broadcast to every cell of the sorting chain
  typedef struct packed {
    logic                    insert;
    logic                    shift;
    logic                    clear;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/rmwm_cell.sv =====
// one cell of the sorted insertion chain
`timescale 1ns / 1ps

module rmwm_cell
  import rmwm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic                    prev_big_i,
  input  logic                    prev_vld_i,
  input  logic signed [VAL_W-1:0] prev_val_i,
  input  logic                    next_vld_i,
  input  logic signed [VAL_W-1:0] next_val_i,
  output logic                    big_o,
  output logic                    vld_o,
  output logic signed [VAL_W-1:0] val_o
);

  logic                    vld_q, vld_d;
  logic signed [VAL_W-1:0] val_q, val_d;

  // empty cells count as larger than anything
  assign big_o = !vld_q || (val_q > ctrl_i.value);
  assign vld_o = vld_q;
  assign val_o = val_q;

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    priority if (ctrl_i.clear) begin
      vld_d = 1'b0;
    end else if (ctrl_i.shift) begin
      vld_d = next_vld_i;
      val_d = next_val_i;
    end else if (ctrl_i.insert) begin
      if (prev_big_i) begin
        vld_d = prev_vld_i;
        val_d = prev_val_i;
      end else if (big_o) begin
        vld_d = 1'b1;
        val_d = ctrl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== hw/rtl/row_median_with_missing.sv =====
// row median with missing values: top level, control and cell chain
`timescale 1ns / 1ps

// Takes one element beat per cycle on the input channel (in_valid_i, in_stall_o,
// in_data_i) and returns one result beat per row on the output channel
// (out_valid_o, out_stall_i, out_data_o): twice the median with one fraction
// bit, and a status of ok, missing or empty.
// Kept elements enter a sorted chain of MaxRowLength cells, one beat a cycle.
// At the beat that ends a row the chain shifts towards cell 0 once per cycle
// until the lower middle element sits in cell 0; the output register is then
// loaded as soon as it is free. The input stalls after the last beat of a row
// until that load. Rows with a missing or empty status skip the shifting.
// The output register holds the result while out_stall_i is high; the next
// row's beats are still accepted meanwhile, but the end of that row waits for
// the register to drain.
// Configuration writes (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// are always taken and belong between rows. Reset sets the row length to one,
// the mode to no missing, empties the chain and clears the output valid flag.

module row_median_with_missing
  import rmwm_pkg::*;
#(
  parameter int unsigned MaxRowLength = RMWM_MAX_ROW_LENGTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CntW  = $clog2(MaxRowLength + 1);
  localparam int unsigned UpIdx = (MaxRowLength > 1) ? 1 : 0;

  typedef enum logic {
    ST_ACCEPT,
    ST_DRAIN
  } state_e;

  state_e              state_q;
  logic [ROW_LEN_W-1:0] row_len_q;
  logic [MODE_W-1:0]   mode_q;
  logic [CntW-1:0]     kept_q, kept_d;
  logic [CntW-1:0]     seen_q, seen_inc;
  logic                miss_seen_q, miss_seen_d;
  logic [CntW-1:0]     drain_q;
  logic [1:0]          status_q, status_d;
  logic                odd_q;
  logic                out_valid_q;
  out_beat_t           out_data_q;

  logic                accept, store, row_end, out_free, finish;
  logic [CntW-1:0]     eff_len;
  cell_ctrl_t          ctrl;
  logic signed [TWICE_W-1:0] sum;

  logic                    big [MaxRowLength];
  logic                    vld [MaxRowLength];
  logic signed [VAL_W-1:0] val [MaxRowLength];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_ACCEPT);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    if (row_len_q == '0) begin
      eff_len = CntW'(1);
    end else if (32'(row_len_q) > 32'(MaxRowLength)) begin
      eff_len = CntW'(MaxRowLength);
    end else begin
      eff_len = CntW'(row_len_q);
    end
  end

  always_comb begin
    miss_seen_d = miss_seen_q;
    priority if (mode_q == MODE_NONE) begin
      store = 1'b1;
    end else if (mode_q == MODE_PROPAGATE) begin
      miss_seen_d = miss_seen_q || in_data_i.element_missing;
      store       = !miss_seen_d;
    end else begin
      store = !in_data_i.element_missing;
    end
    store    = store && (32'(kept_q) < 32'(MaxRowLength));
    kept_d   = store ? CntW'(kept_q + 1'b1) : kept_q;
    seen_inc = CntW'(seen_q + 1'b1);
    row_end  = seen_inc >= eff_len;
    priority if ((mode_q == MODE_PROPAGATE) && miss_seen_d) begin
      status_d = STATUS_MISSING;
    end else if (kept_d == '0) begin
      status_d = STATUS_EMPTY;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // lower middle reaches cell 0 once the count runs out
  assign finish = (state_q == ST_DRAIN) && ((status_q != STATUS_OK) || (drain_q == '0))
                  && out_free;

  always_comb begin
    ctrl.insert = accept && store;
    ctrl.shift  = (state_q == ST_DRAIN) && (status_q == STATUS_OK) && (drain_q != '0);
    ctrl.clear  = finish;
    ctrl.value  = in_data_i.element_value;
  end

  assign sum = {val[0][VAL_W-1], val[0]}
             + (odd_q ? {val[0][VAL_W-1], val[0]} : {val[UpIdx][VAL_W-1], val[UpIdx]});

  for (genvar i = 0; i < MaxRowLength; i++) begin : g_cell
    logic                    prev_big, prev_vld, next_vld;
    logic signed [VAL_W-1:0] prev_val, next_val;

    if (i == 0) begin : g_first
      assign prev_big = 1'b0;
      assign prev_vld = 1'b0;
      assign prev_val = '0;
    end else begin : g_mid
      assign prev_big = big[i-1];
      assign prev_vld = vld[i-1];
      assign prev_val = val[i-1];
    end

    if (i == MaxRowLength - 1) begin : g_last
      assign next_vld = 1'b0;
      assign next_val = '0;
    end else begin : g_low
      assign next_vld = vld[i+1];
      assign next_val = val[i+1];
    end

    rmwm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .prev_big_i (prev_big),
      .prev_vld_i (prev_vld),
      .prev_val_i (prev_val),
      .next_vld_i (next_vld),
      .next_val_i (next_val),
      .big_o      (big[i]),
      .vld_o      (vld[i]),
      .val_o      (val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCEPT;
      row_len_q   <= ROW_LEN_W'(1);
      mode_q      <= MODE_NONE;
      kept_q      <= '0;
      seen_q      <= '0;
      miss_seen_q <= 1'b0;
      drain_q     <= '0;
      status_q    <= STATUS_OK;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_ROW_LENGTH) begin
          row_len_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_MISSING_MODE) begin
          mode_q <= cfg_data_i[MODE_W-1:0];
        end
      end

      // a new result may replace the one leaving in the same cycle
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_ACCEPT: begin
          if (accept) begin
            if (row_end) begin
              kept_q      <= '0;
              seen_q      <= '0;
              miss_seen_q <= 1'b0;
              status_q    <= status_d;
              odd_q       <= kept_d[0];
              drain_q     <= CntW'(kept_d - 1'b1) >> 1;
              state_q     <= ST_DRAIN;
            end else begin
              kept_q      <= kept_d;
              seen_q      <= seen_inc;
              miss_seen_q <= miss_seen_d;
            end
          end
        end
        ST_DRAIN: begin
          if (ctrl.shift) begin
            drain_q <= drain_q - 1'b1;
          end else if (finish) begin
            state_q <= ST_ACCEPT;
          end
        end
        default: begin
          state_q <= ST_ACCEPT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q.median_status <= status_q;
      out_data_q.twice_median  <= (status_q == STATUS_OK) ? sum : '0;
    end
  end

endmodule

// ===== hw/rtl/rmwm_checker.sv =====
// port checks for the row median block, bound to the top level
`timescale 1ns / 1ps

module rmwm_checker
  import rmwm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  // a stalled result beat holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // only an ok result carries a median
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.median_status != STATUS_OK)
    |-> (out_data_o.twice_median == '0))
    else $error("median not zero on a non-ok status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.median_status != STATUS_BAD))
    else $error("undefined status code");

  // a finishing row cannot complete into a held result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_valid_o && out_stall_i |=> in_stall_o)
    else $error("row finished while result register was stalled");

endmodule

bind row_median_with_missing rmwm_checker u_rmwm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== sim/row_median_with_missing_test.sv =====
// testbench for the row median block: directed and random rows checked against a local median model
`timescale 1ns / 1ps

module row_median_with_missing_test;
  import rmwm_pkg::*;

  // register indexes past the end of the register list, writes are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HIGH = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_DROP      = 2'd2;
  localparam logic [MODE_W-1:0]    MODE_DROP_ALT  = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

  localparam int SETTLE_CYCLES = RMWM_MAX_ROW_LENGTH / 2 + 8;
  localparam int QUIET_LIMIT   = 5000;
  localparam int MAX_GAP       = 60;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_beat_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_beat_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // register copies and row state of the median model
  logic [ROW_LEN_W-1:0]    cfg_row_length = 9'd1;
  logic [MODE_W-1:0]       cfg_mode       = MODE_NONE;
  logic signed [VAL_W-1:0] kept_values [$];
  int unsigned             elements_in_row;
  bit                      missing_in_row;
  out_beat_t               expected_medians [$];

  int fail_count;
  int rows_checked;
  int elements_sent;
  int register_writes;
  int sender_idle_pct;
  int receiver_stall_pct;
  bit hold_armed;
  int hold_cycles;
  int hold_left;
  int quiet_cycles;

  row_median_with_missing #(
    .MaxRowLength(RMWM_MAX_ROW_LENGTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_medians.size() == 0) begin
        $error("result beat with no row pending: twice_median %0d median_status %0d",
               out_data_o.twice_median, out_data_o.median_status);
        fail_count++;
      end else begin
        want = expected_medians.pop_front();
        rows_checked++;
        if (out_data_o.twice_median !== want.twice_median) begin
          $error("twice_median: expected %0d, got %0d", want.twice_median,
                 out_data_o.twice_median);
          fail_count++;
        end
        if (out_data_o.median_status !== want.median_status) begin
          $error("median_status: expected %0d, got %0d", want.median_status,
                 out_data_o.median_status);
          fail_count++;
        end
      end
    end
    if (hold_armed) begin
      hold_left  = hold_cycles;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // advances the row model by one element and queues the median at a row end
  task automatic predict_element(input in_beat_t beat);
    bit          keep;
    int unsigned row_end;
    int          j;
    longint      v;
    longint      sorted_vals [$];
    out_beat_t   median;
    if (cfg_mode == MODE_NONE) begin
      keep = 1'b1;
    end else if (cfg_mode == MODE_PROPAGATE) begin
      if (beat.element_missing) missing_in_row = 1'b1;
      keep = !missing_in_row;
    end else begin
      keep = !beat.element_missing;
    end
    if (keep && kept_values.size() < RMWM_MAX_ROW_LENGTH) kept_values.push_back(beat.element_value);
    elements_in_row++;
    row_end = cfg_row_length;
    if (row_end == 0) row_end = 1;
    if (row_end > RMWM_MAX_ROW_LENGTH) row_end = RMWM_MAX_ROW_LENGTH;
    if (elements_in_row >= row_end) begin
      median = '0;
      if (cfg_mode == MODE_PROPAGATE && missing_in_row) begin
        median.median_status = STATUS_MISSING;
      end else if (kept_values.size() == 0) begin
        median.median_status = STATUS_EMPTY;
      end else begin
        foreach (kept_values[i]) begin
          v = kept_values[i];
          sorted_vals.push_back(v);
          j = i;
          while (j > 0 && sorted_vals[j-1] > v) begin
            sorted_vals[j] = sorted_vals[j-1];
            j--;
          end
          sorted_vals[j] = v;
        end
        j = sorted_vals.size();
        if (j % 2 == 1) v = 2 * sorted_vals[j/2];
        else v = sorted_vals[j/2 - 1] + sorted_vals[j/2];
        median.median_status = STATUS_OK;
        median.twice_median  = TWICE_W'(v);
      end
      expected_medians.push_back(median);
      kept_values.delete();
      elements_in_row = 0;
      missing_in_row  = 1'b0;
    end
  endtask

  // offers one beat, holds it until taken, then maybe idles
  task automatic send_element(input logic signed [VAL_W-1:0] value, input logic missing);
    int       gap;
    in_beat_t beat;
    beat.element_value   = value;
    beat.element_missing = missing;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_element(beat);
    elements_sent++;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_ROW_LENGTH) cfg_row_length = data[ROW_LEN_W-1:0];
    else if (idx == CFG_MISSING_MODE) cfg_mode = data[MODE_W-1:0];
    register_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stops sending and waits for every pending row plus the block's latency
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return -VAL_MAX;
      3, 4, 5: return VAL_W'(int'($urandom_range(16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // share of missing elements for the next row, shaped by the current mode
  function automatic int row_missing_pct();
    int unsigned r;
    r = $urandom_range(99);
    if (cfg_mode == MODE_NONE) return 50;
    if (cfg_mode == MODE_PROPAGATE) return (r < 70) ? 0 : 25;
    if (r < 40) return 0;
    if (r < 80) return 30;
    if (r < 92) return 100;
    return 70;
  endfunction

  task automatic send_random_row(input int unsigned len, input int missing_pct);
    for (int unsigned k = 0; k < len; k++) begin
      send_element(random_value(), $urandom_range(99) < missing_pct);
    end
  endtask

  // reset values: one element per row, missing flag ignored
  task automatic test_reset_defaults();
    send_element(VAL_MAX, 1'b0);
    send_element(VAL_MIN, 1'b1);
    send_element(-VAL_MAX, 1'b0);
    send_element('0, 1'b1);
    send_element(-1, 1'b0);
    send_element(1, 1'b1);
  endtask

  task automatic test_even_and_odd_rows();
    settle_block();
    write_register(CFG_ROW_LENGTH, CFG_DATA_W'(2));
    send_element(VAL_MAX, 1'b0);
    send_element(VAL_MAX, 1'b0);
    send_element(VAL_MIN, 1'b0);
    send_element(VAL_MIN, 1'b1);
    // half-way value between the extremes
    send_element(VAL_MAX, 1'b0);
    send_element(VAL_MIN, 1'b0);
    settle_block();
    write_register(CFG_ROW_LENGTH, CFG_DATA_W'(3));
    send_element(5, 1'b0);
    send_element(-3, 1'b0);
    send_element(7, 1'b1);
  endtask

  task automatic test_missing_modes();
    settle_block();
    write_register(CFG_ROW_LENGTH, CFG_DATA_W'(2));
    write_register(CFG_MISSING_MODE, CFG_DATA_W'(MODE_PROPAGATE));
    send_element(1, 1'b0);
    send_element(2, 1'b1);
    // nothing kept, missing status still wins over empty
    send_element(9, 1'b1);
    send_element(3, 1'b0);
    settle_block();
    write_register(CFG_MISSING_MODE, CFG_DATA_W'(MODE_DROP));
    send_element(11, 1'b1);
    send_element(4, 1'b0);
    send_element(2, 1'b1);
    send_element(3, 1'b1);
    settle_block();
    write_register(CFG_MISSING_MODE, CFG_DATA_W'(MODE_DROP_ALT));
    send_element(-5, 1'b1);
    send_element(6, 1'b0);
  endtask

  // zero length, ignored indexes, saturated and full length rows
  task automatic test_register_corners();
    settle_block();
    write_register(CFG_MISSING_MODE, CFG_DATA_W'(MODE_NONE));
    write_register(CFG_ROW_LENGTH, '0);
    send_element(random_value(), 1'b0);
    send_element(random_value(), 1'b1);
    settle_block();
    write_register(CFG_SPARE_LOW, CFG_DATA_W'($urandom));
    write_register(CFG_SPARE_HIGH, CFG_DATA_W'($urandom));
    send_element(random_value(), 1'b0);
    send_element(random_value(), 1'b1);
    settle_block();
    write_register(CFG_ROW_LENGTH, '1);
    write_register(CFG_MISSING_MODE, CFG_DATA_W'(MODE_DROP));
    send_random_row(RMWM_MAX_ROW_LENGTH, 20);
    settle_block();
    write_register(CFG_ROW_LENGTH, CFG_DATA_W'(RMWM_MAX_ROW_LENGTH));
    write_register(CFG_MISSING_MODE, CFG_DATA_W'(MODE_NONE));
    send_random_row(RMWM_MAX_ROW_LENGTH, 50);
  endtask

  // register writes between beats of an unfinished row
  task automatic test_mid_row_changes();
    sender_idle_pct    = 37;
    receiver_stall_pct = 37;
    repeat (24) begin
      settle_block();
      if ($urandom_range(1)) write_register(CFG_ROW_LENGTH, CFG_DATA_W'($urandom_range(1, 12)));
      else write_register(CFG_MISSING_MODE, CFG_DATA_W'($urandom));
      repeat ($urandom_range(1, 9)) send_element(random_value(), $urandom_range(99) < 30);
    end
    // close whatever row is still open
    settle_block();
    write_register(CFG_ROW_LENGTH, CFG_DATA_W'(1));
    send_element(random_value(), 1'b0);
  endtask

  // long receiver hold so the block backs up into its input
  task automatic test_output_backpressure();
    settle_block();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    write_register(CFG_ROW_LENGTH, CFG_DATA_W'(1));
    write_register(CFG_MISSING_MODE, CFG_DATA_W'(MODE_NONE));
    hold_cycles = 400;
    hold_armed  = 1'b1;
    repeat (80) send_element(random_value(), 1'b0);
    settle_block();
    write_register(CFG_ROW_LENGTH, CFG_DATA_W'(4));
    write_register(CFG_MISSING_MODE, CFG_DATA_W'(MODE_PROPAGATE));
    hold_cycles = 300;
    hold_armed  = 1'b1;
    repeat (20) send_random_row(4, row_missing_pct());
  endtask

  task automatic test_random_rows(input int sender_pct, input int receiver_pct);
    int unsigned           len;
    int unsigned           sent;
    int unsigned           r;
    logic [CFG_DATA_W-1:0] mode_word;
    settle_block();
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    repeat (5) begin
      settle_block();
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(1, 6);
      else if (r < 95) len = $urandom_range(7, 40);
      else len = $urandom_range(41, 100);
      // upper bits of the mode word are don't-care
      mode_word = CFG_DATA_W'($urandom);
      write_register(CFG_ROW_LENGTH, CFG_DATA_W'(len));
      write_register(CFG_MISSING_MODE, mode_word);
      sent = 0;
      while (sent < 55) begin
        send_random_row(len, row_missing_pct());
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_even_and_odd_rows();
    test_missing_modes();
    test_register_corners();
    test_mid_row_changes();
    test_output_backpressure();
    test_random_rows(0, 0);
    test_random_rows(76, 0);
    test_random_rows(0, 76);
    test_random_rows(37, 37);
    settle_block();
    $display("sent %0d elements, compared %0d row results, made %0d register writes",
             elements_sent, rows_checked, register_writes);
    $display("covered lengths 0 to 511, all mode codes, mid-row writes and a long output hold");
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== row_median_with_missing.f =====
hw/rtl/rmwm_pkg.sv
hw/rtl/rmwm_cell.sv
hw/rtl/row_median_with_missing.sv
hw/rtl/rmwm_checker.sv
sim/row_median_with_missing_test.sv
